>>> rtl/core/watch_menu_event_controller_unit_macros.svh
// ---------------------------------------------------------------------------
// Watch menu event controller assertion macros
// Shared assertion wrappers clocked on clk_i and reset by rst_ni
// ---------------------------------------------------------------------------
`ifndef WATCH_MENU_EVENT_CONTROLLER_UNIT_MACROS_SVH
`define WATCH_MENU_EVENT_CONTROLLER_UNIT_MACROS_SVH

// property checked at every edge outside reset
`define WMEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the next edge, outside reset
`define WMEC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/wmec_pkg.sv
// ---------------------------------------------------------------------------
// Watch menu event controller package
// Event, action and menu codes, setting limits and the bcd helper
// ---------------------------------------------------------------------------
package wmec_pkg;

  // event codes carried in the cmd field
  typedef enum logic [3:0] {
    EV_ALARM  = 4'd0,
    EV_B1     = 4'd1,
    EV_B2     = 4'd2,
    EV_B3     = 4'd3,
    EV_B4     = 4'd4,
    EV_GTIMER = 4'd5,
    EV_GDONE  = 4'd6,
    EV_TIME   = 4'd7,
    EV_GBEGIN = 4'd8
  } event_e;

  // action codes in the result
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_SYNC  = 3'd3,
    ACT_DRAW  = 3'd4
  } action_e;

  // menu codes
  typedef enum logic [1:0] {
    MENU_MAIN  = 2'd0,
    MENU_SETUP = 2'd1,
    MENU_SAT   = 2'd2
  } menu_e;

  // options entries
  localparam logic [2:0] ITEM_ALARM_EN = 3'd0;
  localparam logic [2:0] ITEM_HOUR     = 3'd1;
  localparam logic [2:0] ITEM_MINUTE   = 3'd2;
  localparam logic [2:0] ITEM_SYNC_EN  = 3'd3;
  localparam logic [2:0] ITEM_ZONE     = 3'd4;
  localparam logic [2:0] ITEM_GSYNC    = 3'd5;
  localparam logic [2:0] LAST_ITEM     = ITEM_GSYNC;

  // setting limits
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINUTE_MAX  = 6'd55;
  localparam logic [5:0] MINUTE_STEP = 6'd5;
  localparam logic [6:0] ZONE_MAX    = 7'd100;
  localparam logic [6:0] ZONE_MIN    = 7'd1;

  // two bcd digits of a value below 64, tens picked by a priority chain of compares
  function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] rest;
    if (v >= 6'd60) tens = 3'd6;
    else if (v >= 6'd50) tens = 3'd5;
    else if (v >= 6'd40) tens = 3'd4;
    else if (v >= 6'd30) tens = 3'd3;
    else if (v >= 6'd20) tens = 3'd2;
    else if (v >= 6'd10) tens = 3'd1;
    else tens = 3'd0;
    // tens times ten as eight plus two
    rest = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {tens, rest[3:0]};
  endfunction

endpackage

>>> rtl/core/watch_menu_event_controller_unit.sv
// ---------------------------------------------------------------------------
// Watch menu event controller
// Event decoder with held menu, selection and alarm/sync/timezone settings
// ---------------------------------------------------------------------------
// One event is taken per transfer on the slave stream and one result leaves
// on the master stream for each. A new event can be taken every clock while
// the skid entry is empty; its result is registered in the result register
// or, on a stall, in the skid entry. The settings update in the same edge
// that takes the event, so back-to-back events see each other at once. The
// result register plus one skid entry let the slave side take one more event
// during a master stall; then s_axis_tready drops until the skid entry drains.
module watch_menu_event_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] cmd, [4] alarm_ringing, [7:5] zero
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] action, [4:3] menu_now, [7:5] item_now,
                                      // [8] alarm_on, [14:9] alarm_hour_bcd,
                                      // [21:15] alarm_minute_bcd, [22] sync_on,
                                      // [29:23] zone_setting, [31:30] zero
);
  import wmec_pkg::*;

  // held state
  menu_e      menu_q, menu_d;
  logic [2:0] item_q, item_d;
  logic       alarm_en_q, alarm_en_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic       sync_en_q, sync_en_d;
  logic [6:0] zone_q, zone_d;

  // output stage
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        skid_valid_q;
  logic [31:0] skid_data_q;

  logic        accept;
  logic        out_free;
  event_e      ev;
  logic        ringing;
  logic        button;
  action_e     act;
  logic [6:0]  hour_bcd;
  logic [6:0]  minute_bcd;
  logic [31:0] result;

  assign ev      = event_e'(s_axis_tdata[3:0]);
  assign ringing = s_axis_tdata[4];
  assign button  = (s_axis_tdata[3:0] inside {[EV_B1 : EV_B4]});

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // event decode in priority order
  always_comb begin
    menu_d     = menu_q;
    item_d     = item_q;
    alarm_en_d = alarm_en_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    sync_en_d  = sync_en_q;
    zone_d     = zone_q;
    act        = ACT_NONE;
    if (!ringing && ev == EV_ALARM) begin
      act = ACT_START;
    end else if (ringing && button) begin
      act = ACT_STOP;
    end else if (ev == EV_GTIMER) begin
      act = ACT_SYNC;
    end else if (menu_q == MENU_SAT && ev == EV_GDONE) begin
      menu_d = MENU_MAIN;
      act    = ACT_DRAW;
    end else if (menu_q == MENU_SETUP && button) begin
      act = ACT_DRAW;
      case (ev)
        EV_B4: begin
          menu_d = MENU_MAIN;
        end
        EV_B3: begin
          case (item_q)
            ITEM_ALARM_EN: alarm_en_d = !alarm_en_q;
            ITEM_HOUR:     hour_d = (hour_q >= HOUR_MAX) ? '0 : hour_q + 5'd1;
            ITEM_MINUTE:   minute_d = (minute_q >= MINUTE_MAX) ? '0
                                                               : minute_q + MINUTE_STEP;
            ITEM_SYNC_EN:  sync_en_d = !sync_en_q;
            ITEM_ZONE:     zone_d = (zone_q >= ZONE_MAX) ? ZONE_MIN : zone_q + 7'd1;
            ITEM_GSYNC:    act = ACT_SYNC;
            default:       act = ACT_DRAW;
          endcase
        end
        EV_B1: begin
          item_d = (item_q == '0) ? LAST_ITEM : item_q - 3'd1;
        end
        default: begin
          item_d = (item_q == LAST_ITEM) ? '0 : item_q + 3'd1;
        end
      endcase
    end else if (menu_q == MENU_MAIN && ev == EV_B4) begin
      menu_d = MENU_SETUP;
      item_d = '0;
      act    = ACT_DRAW;
    end else if (ev == EV_TIME && menu_q == MENU_MAIN) begin
      act = ACT_DRAW;
    end else if (ev == EV_GBEGIN) begin
      menu_d = MENU_SAT;
      act    = ACT_DRAW;
    end
  end

  // result word from the updated settings
  assign hour_bcd   = bin_to_bcd({1'b0, hour_d});
  assign minute_bcd = bin_to_bcd(minute_d);
  assign result = {2'b00, zone_d, sync_en_d, minute_bcd, hour_bcd[5:0],
                   alarm_en_d, item_d, menu_d, act};

  // settings update on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_q     <= MENU_MAIN;
      item_q     <= '0;
      alarm_en_q <= 1'b0;
      hour_q     <= '0;
      minute_q   <= '0;
      sync_en_q  <= 1'b0;
      zone_q     <= ZONE_MIN;
    end else if (accept) begin
      menu_q     <= menu_d;
      item_q     <= item_d;
      alarm_en_q <= alarm_en_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      sync_en_q  <= sync_en_d;
      zone_q     <= zone_d;
    end
  end

  // result register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end else if (accept) begin
      skid_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/wmec_checker.sv
// ---------------------------------------------------------------------------
// Watch menu event controller checker
// Port-level checks on the result stream and the handshake coupling
// ---------------------------------------------------------------------------
`include "watch_menu_event_controller_unit_macros.svh"

module wmec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import wmec_pkg::*;

  logic       stall;
  logic [2:0] res_action;
  logic [1:0] res_menu;
  logic [2:0] res_item;
  logic [5:0] res_hour;
  logic [6:0] res_zone;
  logic       codes_ok;
  logic       range_ok;

  // result fields
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign res_action = m_axis_tdata[2:0];
  assign res_menu   = m_axis_tdata[4:3];
  assign res_item   = m_axis_tdata[7:5];
  assign res_hour   = m_axis_tdata[14:9];
  assign res_zone   = m_axis_tdata[29:23];

  // code and range checks on the result word
  assign codes_ok = (res_menu <= MENU_SAT) && (res_item <= LAST_ITEM) &&
                    (res_action <= ACT_DRAW);
  assign range_ok = (res_zone >= ZONE_MIN) && (res_zone <= ZONE_MAX) &&
                    (res_hour <= 6'h23) && (res_hour[3:0] <= 4'd9);

  // a stalled result keeps its data
  `WMEC_ASSERT_NEXT(a_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "held result changed")

  // an empty output stage never back-pressures the input
  `WMEC_ASSERT(a_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  // menu, selection and action stay within their codes
  `WMEC_ASSERT(a_codes, m_axis_tvalid |-> codes_ok, "result code out of range")

  // timezone and alarm hour stay within their ranges
  `WMEC_ASSERT(a_range, m_axis_tvalid |-> range_ok, "setting out of range")

endmodule

bind watch_menu_event_controller_unit wmec_checker u_wmec_checker (.*);
